[hw/rtl/ncla_pkg.sv]
package ncla_pkg;

    // Default sizes
    localparam int NODES_DEF   = 4;
    localparam int THREADS_DEF = 64;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int TID_W   = 6;
    localparam int NID_W   = 2;
    localparam int KIND_W  = 3;
    localparam int BATCH_W = 8;

    localparam logic [BATCH_W-1:0] BATCH_RESET = 8'd64;

    // Request codes
    localparam logic [OP_W-1:0] OP_LOCK    = 2'd0;
    localparam logic [OP_W-1:0] OP_TRYLOCK = 2'd1;
    localparam logic [OP_W-1:0] OP_UNLOCK  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] K_GRANTED  = 3'd0;
    localparam logic [KIND_W-1:0] K_QUEUED   = 3'd1;
    localparam logic [KIND_W-1:0] K_BUSY     = 3'd2;
    localparam logic [KIND_W-1:0] K_RELEASED = 3'd3;
    localparam logic [KIND_W-1:0] K_ERROR    = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TID_W-1:0]  who;
        logic [NID_W-1:0]  where_node;
        logic              last;
    } result_t;

endpackage

[hw/rtl/ncla_queue_mem.sv]
module ncla_queue_mem #(
    parameter int DEPTH = ncla_pkg::NODES_DEF * ncla_pkg::THREADS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [ncla_pkg::TID_W-1:0] wdata,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [ncla_pkg::TID_W-1:0] rdata
);

    logic [ncla_pkg::TID_W-1:0] mem [DEPTH];
    logic [ncla_pkg::TID_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ncla_out_stage.sv]
module ncla_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ncla_pkg::result_t din,
    output logic              space,
    output logic              valid,
    input  logic              ready,
    output ncla_pkg::result_t dout
);

    logic              valid_reg;
    ncla_pkg::result_t data_reg;

    // Free when empty or when the held result transfers this cycle
    assign space = !valid_reg || ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign valid = valid_reg;
    assign dout  = data_reg;

endmodule

[hw/rtl/numa_cohort_lock_arbiter_core.sv]
// Cohort lock manager: one global lock shared by NODES locality nodes, each node with a FIFO
// of waiting thread ids kept in one synchronous RAM (NODES*THREADS entries, one write and one
// read port, registered read data); per-node head, fill and batch credit plus the global lock
// state sit in flip-flops. For lock and trylock the decision comes from the flip-flop state,
// the push is a single RAM write and the result is loaded into the output register at the
// input transfer. An unlock that finds the lock free or the owner's queue empty fails at the
// input transfer. Any other unlock reads the owner's queue head for the owner check, and each
// queue head it reports costs one RAM read: in ST_HEAD it fails the owner check or only
// releases, a same-node handoff goes on to ST_NEXT for the new owner, and a release that
// passes the global lock to a waiting node head first reads that node's head in ST_PICK
// and then goes on to ST_NEXT. A following request is taken once the sequencer is back in
// ST_IDLE after the last result of an unlock is loaded, and any request waits while the
// output register holds a result that is not taken. A successful unlock emits a released
// result and, when the lock passes on, a granted result for the new owner; last marks the
// final result of each request. The RAM needs no clearing after reset: only entries that were
// pushed are ever read. batch_limit is written through cfg_write and cfg_data and resets to
// 64; the user must write it only while the block is idle, the block does not enforce it.
module numa_cohort_lock_arbiter_core #(
    parameter int NODES   = ncla_pkg::NODES_DEF,
    parameter int THREADS = ncla_pkg::THREADS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [ncla_pkg::BATCH_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ncla_pkg::OP_W-1:0]     opcode,
    input  logic [ncla_pkg::TID_W-1:0]    thread_id,
    input  logic [ncla_pkg::NID_W-1:0]    node_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ncla_pkg::KIND_W-1:0]   kind,
    output logic [ncla_pkg::TID_W-1:0]    who,
    output logic [ncla_pkg::NID_W-1:0]    where_node,
    output logic                          last
);

    localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PTR_W   = $clog2(THREADS);
    localparam int CNT_W   = $clog2(THREADS + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int DEPTH   = NODES * THREADS;
    localparam int ADDR_W  = $clog2(DEPTH);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // take a request
    localparam logic [1:0] ST_HEAD = 2'd1;  // owner's queue head arrives from RAM
    localparam logic [1:0] ST_PICK = 2'd2;  // read the granted node's queue head
    localparam logic [1:0] ST_NEXT = 2'd3;  // new owner arrives from RAM

    // Position base+step within a node's circular queue; base+step stays below 2*THREADS
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] step);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(step);
        if (s >= SUM_W'(THREADS))
        begin
            s = s - SUM_W'(THREADS);
        end
        return PTR_W'(s);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [NODE_AW-1:0] nd,
                                                   input logic [PTR_W-1:0] pos);
        return ADDR_W'(32'(nd) * THREADS + 32'(pos));
    endfunction

    // Control state
    logic [1:0]                    state_reg, state_next;
    logic [PTR_W-1:0]              head_reg [NODES];
    logic [PTR_W-1:0]              head_next [NODES];
    logic [CNT_W-1:0]              count_reg [NODES];
    logic [CNT_W-1:0]              count_next [NODES];
    logic [ncla_pkg::BATCH_W-1:0]  credit_reg [NODES];
    logic [ncla_pkg::BATCH_W-1:0]  credit_next [NODES];
    logic                          held_reg, held_next;
    logic [NODE_AW-1:0]            owner_reg, owner_next;
    logic [NODES-1:0]              waiting_reg, waiting_next;
    logic [NODE_AW-1:0]            rr_reg, rr_next;
    logic [ncla_pkg::BATCH_W-1:0]  batch_limit_reg;

    // Per-unlock payload
    logic [ncla_pkg::TID_W-1:0]    tid_reg, tid_next;
    logic [ncla_pkg::NID_W-1:0]    nid_reg, nid_next;
    logic [NODE_AW-1:0]            grant_reg, grant_next;

    // RAM port
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic                          mem_re;
    logic [ADDR_W-1:0]             mem_raddr;
    logic [ncla_pkg::TID_W-1:0]    rd_data;

    // Output register port
    logic                          space;
    logic                          res_load;
    ncla_pkg::result_t             res;
    ncla_pkg::result_t             out_data;

    // One node-table entry is looked at per cycle
    logic [NODE_AW-1:0]            sel_node;
    logic [PTR_W-1:0]              sel_head;
    logic [CNT_W-1:0]              sel_cnt;
    logic [ncla_pkg::BATCH_W-1:0]  sel_credit;
    logic [PTR_W-1:0]              push_pos;
    logic [PTR_W-1:0]              head_inc;
    logic                          multi;
    logic                          bad;

    // Round-robin choice after a global release
    logic [NODES-1:0]              owner_mask;
    logic [NODES-1:0]              waits_after;
    logic [NODE_AW-1:0]            pick;
    logic [NODES-1:0]              pick_mask;
    logic [NODE_AW-1:0]            pick_inc;

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sel_node = (opcode == ncla_pkg::OP_UNLOCK) ? owner_reg : NODE_AW'(node_id);
            end
            ST_PICK:
            begin
                sel_node = grant_reg;
            end
            default:
            begin
                sel_node = owner_reg;
            end
        endcase
    end

    assign sel_head   = head_reg[sel_node];
    assign sel_cnt    = count_reg[sel_node];
    assign sel_credit = credit_reg[sel_node];
    assign push_pos   = wrap_add(sel_head, sel_cnt);
    assign head_inc   = wrap_add(sel_head, CNT_W'(1));
    assign multi      = (sel_cnt > CNT_W'(1));

    assign bad = (opcode != ncla_pkg::OP_LOCK && opcode != ncla_pkg::OP_TRYLOCK
                  && opcode != ncla_pkg::OP_UNLOCK)
                 || (32'(node_id) >= NODES) || (32'(thread_id) >= THREADS);

    // A remaining local head of the releasing node joins the waiters
    assign owner_mask  = NODES'(1) << owner_reg;
    assign waits_after = waiting_reg | (multi ? owner_mask : '0);

    always_comb
    begin
        int  c;
        logic found;
        pick  = rr_reg;
        found = 1'b0;
        for (int i = 0; i < NODES; i++)
        begin
            c = int'(rr_reg) + i;
            if (c >= NODES)
            begin
                c = c - NODES;
            end
            if (!found && waits_after[NODE_AW'(c)])
            begin
                pick  = NODE_AW'(c);
                found = 1'b1;
            end
        end
    end

    assign pick_mask = NODES'(1) << pick;
    assign pick_inc  = (pick == NODE_AW'(NODES - 1)) ? '0 : pick + NODE_AW'(1);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        credit_next  = credit_reg;
        held_next    = held_reg;
        owner_next   = owner_reg;
        waiting_next = waiting_reg;
        rr_next      = rr_reg;
        tid_next     = tid_reg;
        nid_next     = nid_reg;
        grant_next   = grant_reg;
        mem_we       = 1'b0;
        mem_waddr    = slot_addr(sel_node, push_pos);
        mem_re       = 1'b0;
        mem_raddr    = slot_addr(sel_node, sel_head);
        res_load     = 1'b0;
        res.kind       = ncla_pkg::K_ERROR;
        res.who        = thread_id;
        res.where_node = node_id;
        res.last       = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && space)
                begin
                    if (bad)
                    begin
                        res_load = 1'b1;
                    end
                    else
                    begin
                        case (opcode)
                            ncla_pkg::OP_LOCK:
                            begin
                                res_load = 1'b1;
                                if (sel_cnt != CNT_W'(THREADS))
                                begin
                                    // Append to the node queue
                                    mem_we               = 1'b1;
                                    count_next[sel_node] = sel_cnt + CNT_W'(1);
                                    if (sel_cnt != '0)
                                    begin
                                        res.kind = ncla_pkg::K_QUEUED;
                                    end
                                    else if (!held_reg)
                                    begin
                                        held_next  = 1'b1;
                                        owner_next = sel_node;
                                        res.kind   = ncla_pkg::K_GRANTED;
                                    end
                                    else
                                    begin
                                        waiting_next[sel_node] = 1'b1;
                                        res.kind               = ncla_pkg::K_QUEUED;
                                    end
                                end
                            end
                            ncla_pkg::OP_TRYLOCK:
                            begin
                                res_load = 1'b1;
                                if (sel_cnt != '0 || held_reg)
                                begin
                                    res.kind = ncla_pkg::K_BUSY;
                                end
                                else
                                begin
                                    mem_we               = 1'b1;
                                    count_next[sel_node] = CNT_W'(1);
                                    held_next            = 1'b1;
                                    owner_next           = sel_node;
                                    res.kind             = ncla_pkg::K_GRANTED;
                                end
                            end
                            ncla_pkg::OP_UNLOCK:
                            begin
                                if (!held_reg || sel_cnt == '0)
                                begin
                                    res_load = 1'b1;
                                end
                                else
                                begin
                                    // Fetch the owner's queue head for the owner check
                                    mem_re     = 1'b1;
                                    tid_next   = thread_id;
                                    nid_next   = node_id;
                                    state_next = ST_HEAD;
                                end
                            end
                            default:
                            begin
                                res_load = 1'b1;
                            end
                        endcase
                    end
                end
            end

            ST_HEAD:
            begin
                if (space)
                begin
                    res_load = 1'b1;
                    res.who  = tid_reg;
                    if (rd_data != tid_reg)
                    begin
                        res.where_node = nid_reg;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        res.kind              = ncla_pkg::K_RELEASED;
                        res.where_node        = ncla_pkg::NID_W'(owner_reg);
                        head_next[owner_reg]  = head_inc;
                        count_next[owner_reg] = sel_cnt - CNT_W'(1);
                        if (multi && sel_credit != '0)
                        begin
                            // Same-node handoff: read the next thread in line
                            credit_next[owner_reg] = sel_credit - ncla_pkg::BATCH_W'(1);
                            mem_re                 = 1'b1;
                            mem_raddr              = slot_addr(owner_reg, head_inc);
                            res.last               = 1'b0;
                            grant_next             = owner_reg;
                            state_next             = ST_NEXT;
                        end
                        else
                        begin
                            if (multi)
                            begin
                                credit_next[owner_reg] = batch_limit_reg;
                            end
                            if (waits_after == '0)
                            begin
                                held_next    = 1'b0;
                                waiting_next = waits_after;
                                state_next   = ST_IDLE;
                            end
                            else
                            begin
                                // Pass the global lock to the next waiting node
                                res.last     = 1'b0;
                                waiting_next = waits_after & ~pick_mask;
                                held_next    = 1'b1;
                                owner_next   = pick;
                                rr_next      = pick_inc;
                                grant_next   = pick;
                                state_next   = ST_PICK;
                            end
                        end
                    end
                end
            end

            ST_PICK:
            begin
                mem_re     = 1'b1;
                state_next = ST_NEXT;
            end

            ST_NEXT:
            begin
                if (space)
                begin
                    res_load       = 1'b1;
                    res.kind       = ncla_pkg::K_GRANTED;
                    res.who        = rd_data;
                    res.where_node = ncla_pkg::NID_W'(grant_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE) && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            held_reg        <= 1'b0;
            owner_reg       <= '0;
            waiting_reg     <= '0;
            rr_reg          <= '0;
            batch_limit_reg <= ncla_pkg::BATCH_RESET;
            for (int i = 0; i < NODES; i++)
            begin
                head_reg[i]   <= '0;
                count_reg[i]  <= '0;
                credit_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            owner_reg   <= owner_next;
            waiting_reg <= waiting_next;
            rr_reg      <= rr_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            credit_reg  <= credit_next;
            if (cfg_write)
            begin
                batch_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg   <= tid_next;
        nid_reg   <= nid_next;
        grant_reg <= grant_next;
    end

    ncla_queue_mem #(
        .DEPTH (DEPTH)
    ) u_queue_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (thread_id),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    ncla_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_load),
        .din   (res),
        .space (space),
        .valid (out_valid),
        .ready (out_ready),
        .dout  (out_data)
    );

    assign kind       = out_data.kind;
    assign who        = out_data.who;
    assign where_node = out_data.where_node;
    assign last       = out_data.last;

    // The RAM is never written and read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("queue RAM write and read collide");

    // Between requests the owning node always has its owner queued
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && held_reg) |-> (count_reg[owner_reg] != '0))
        else $error("global lock held by a node with an empty queue");

    // The owning node is never marked as waiting for the global lock
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && held_reg) |-> !waiting_reg[owner_reg])
        else $error("owner node still marked waiting");

    // A non-final result is always followed by more work on the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && !res.last) |=> (state_reg != ST_IDLE))
        else $error("request ended without its final result");

endmodule

[bench/numa_cohort_lock_arbiter_core_test.sv]
`timescale 1ns / 100ps

module numa_cohort_lock_arbiter_core_test;

    localparam int NODES       = ncla_pkg::NODES_DEF;
    localparam int THREADS     = ncla_pkg::THREADS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 200;

    // The package names only the three legal requests; the fourth code is illegal.
    localparam logic [ncla_pkg::OP_W-1:0] OP_ILLEGAL = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [ncla_pkg::BATCH_W-1:0]  cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic [ncla_pkg::OP_W-1:0]     opcode;
    logic [ncla_pkg::TID_W-1:0]    thread_id;
    logic [ncla_pkg::NID_W-1:0]    node_id;
    logic                          out_valid;
    logic                          out_ready;
    logic [ncla_pkg::KIND_W-1:0]   kind;
    logic [ncla_pkg::TID_W-1:0]    who;
    logic [ncla_pkg::NID_W-1:0]    where_node;
    logic                          last;

    numa_cohort_lock_arbiter_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .thread_id  (thread_id),
        .node_id    (node_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .who        (who),
        .where_node (where_node),
        .last       (last)
    );

    // ------------------------------------------------------------------
    // Lock manager shadow state, updated at every accepted request transfer
    // ------------------------------------------------------------------
    logic [ncla_pkg::TID_W-1:0]   fifo_mem      [NODES][THREADS];
    logic [ncla_pkg::TID_W-1:0]   q_head        [NODES];
    logic [ncla_pkg::TID_W:0]     q_count       [NODES];
    // Nothing in the bench ever sets a pending grant, so this stays clear;
    // keep it so that the lock and trylock paths follow the block.
    logic                         grant_pending [NODES];
    logic [ncla_pkg::BATCH_W:0]   credit        [NODES];
    logic                         lock_taken;
    logic [ncla_pkg::NID_W-1:0]   lock_node;
    logic [NODES-1:0]             node_waiting;
    logic [ncla_pkg::NID_W-1:0]   rr_next;
    logic [ncla_pkg::BATCH_W-1:0] batch_limit_cfg;

    ncla_pkg::result_t outcome_q[$];

    // Run control, driven at the clock edge
    logic src_stall_on;
    logic sink_stall_on;
    logic quiet_tail;
    logic pressure_kick;
    int   pressure_left;
    int   sink_gap;

    int failures;
    int mismatch_lines;
    int cycle_count;
    int requests_sent;
    int handoffs;
    int seen_granted;
    int seen_queued;
    int seen_busy;
    int seen_released;
    int seen_error;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // End the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles, %0d results still due",
                     $realtime, CYCLE_LIMIT, outcome_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: long hold-off counter, random stall bursts, checker
    // ------------------------------------------------------------------

    // Hold the result channel for a long stretch once kicked, so that the
    // output register stays full and the block has to stall its input.
    always @(posedge clk)
    begin
        if (pressure_kick)
            pressure_left <= HOLD_CYCLES;
        else if (pressure_left > 0)
            pressure_left <= pressure_left - 1;
    end

    // A stall burst drops ready and holds it low while sink_gap counts down to zero.
    always @(posedge clk)
    begin
        if (pressure_left > 0)
            out_ready <= 1'b0;
        else if (sink_gap > 0)
        begin
            sink_gap  <= sink_gap - 1;
            out_ready <= 1'b0;
        end
        else if (sink_stall_on && !quiet_tail && $urandom_range(0, 5) == 0)
        begin
            sink_gap  <= $urandom_range(0, 15);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        failures++;
        if (mismatch_lines < MAX_REPORTS)
        begin
            mismatch_lines++;
            $display("%0t: %s expected %0d, got %0d", $realtime, field, want, got);
        end
    endtask

    // Compare every result transfer against the oldest outstanding outcome.
    always @(posedge clk)
    begin
        ncla_pkg::result_t seen;
        ncla_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.kind       = kind;
            seen.who        = who;
            seen.where_node = where_node;
            seen.last       = last;
            case (seen.kind)
                ncla_pkg::K_GRANTED:  seen_granted++;
                ncla_pkg::K_QUEUED:   seen_queued++;
                ncla_pkg::K_BUSY:     seen_busy++;
                ncla_pkg::K_RELEASED: seen_released++;
                default:              seen_error++;
            endcase
            if (outcome_q.size() == 0)
            begin
                failures++;
                if (mismatch_lines < MAX_REPORTS)
                begin
                    mismatch_lines++;
                    $display("%0t: result with nothing outstanding, expected none, got %p",
                             $realtime, seen);
                end
            end
            else
            begin
                want = outcome_q.pop_front();
                if (seen.kind !== want.kind)
                    report_field("kind", 8'(want.kind), 8'(seen.kind));
                if (seen.who !== want.who)
                    report_field("who", 8'(want.who), 8'(seen.who));
                if (seen.where_node !== want.where_node)
                    report_field("where_node", 8'(want.where_node), 8'(seen.where_node));
                if (seen.last !== want.last)
                    report_field("last", 8'(want.last), 8'(seen.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Lock manager prediction
    // ------------------------------------------------------------------
    task automatic queue_outcome(input logic [ncla_pkg::KIND_W-1:0] k,
                                 input logic [ncla_pkg::TID_W-1:0] t,
                                 input logic [ncla_pkg::NID_W-1:0] n, input logic fin);
        ncla_pkg::result_t r;
        r.kind       = k;
        r.who        = t;
        r.where_node = n;
        r.last       = fin;
        outcome_q.push_back(r);
    endtask

    task automatic push_thread(input logic [ncla_pkg::NID_W-1:0] n,
                               input logic [ncla_pkg::TID_W-1:0] t);
        logic [ncla_pkg::TID_W-1:0] slot;
        // Slot index wraps at the FIFO depth
        slot = q_head[n] + q_count[n][ncla_pkg::TID_W-1:0];
        fifo_mem[n][slot] = t;
        q_count[n]++;
    endtask

    task automatic pop_thread(input logic [ncla_pkg::NID_W-1:0] n);
        q_head[n]++;
        q_count[n]--;
    endtask

    // Work out the results of one accepted request and advance the shadow state.
    task automatic arbitrate(input logic [ncla_pkg::OP_W-1:0] op,
                             input logic [ncla_pkg::TID_W-1:0] tid,
                             input logic [ncla_pkg::NID_W-1:0] nid);
        logic [ncla_pkg::NID_W-1:0] own;
        logic [ncla_pkg::NID_W-1:0] m;
        logic                       was_empty;
        logic                       picked;
        int                         i;
        case (op)
            ncla_pkg::OP_LOCK:
            begin
                if (q_count[nid] >= THREADS)
                    queue_outcome(ncla_pkg::K_ERROR, tid, nid, 1'b1);
                else
                begin
                    was_empty = (q_count[nid] == 0);
                    push_thread(nid, tid);
                    if (!was_empty)
                        queue_outcome(ncla_pkg::K_QUEUED, tid, nid, 1'b1);
                    else if (grant_pending[nid])
                    begin
                        grant_pending[nid] = 1'b0;
                        queue_outcome(ncla_pkg::K_GRANTED, tid, nid, 1'b1);
                    end
                    else if (!lock_taken)
                    begin
                        lock_taken = 1'b1;
                        lock_node  = nid;
                        queue_outcome(ncla_pkg::K_GRANTED, tid, nid, 1'b1);
                    end
                    else
                    begin
                        // New head of its node: wait for the global lock
                        node_waiting[nid] = 1'b1;
                        queue_outcome(ncla_pkg::K_QUEUED, tid, nid, 1'b1);
                    end
                end
            end
            ncla_pkg::OP_TRYLOCK:
            begin
                if (q_count[nid] != 0 || (lock_taken && !grant_pending[nid]))
                    queue_outcome(ncla_pkg::K_BUSY, tid, nid, 1'b1);
                else
                begin
                    if (grant_pending[nid])
                        grant_pending[nid] = 1'b0;
                    else
                    begin
                        lock_taken = 1'b1;
                        lock_node  = nid;
                    end
                    push_thread(nid, tid);
                    queue_outcome(ncla_pkg::K_GRANTED, tid, nid, 1'b1);
                end
            end
            ncla_pkg::OP_UNLOCK:
            begin
                // Only the head of the owning node may unlock; node_id plays no part in the decision.
                own = lock_node;
                if (!lock_taken || q_count[own] == 0 || fifo_mem[own][q_head[own]] != tid)
                    queue_outcome(ncla_pkg::K_ERROR, tid, nid, 1'b1);
                else if (q_count[own] > 1 && credit[own] != 0)
                begin
                    // Same-node handoff: spend one credit, keep the global lock
                    credit[own]--;
                    pop_thread(own);
                    handoffs++;
                    queue_outcome(ncla_pkg::K_RELEASED, tid, own, 1'b0);
                    queue_outcome(ncla_pkg::K_GRANTED, fifo_mem[own][q_head[own]], own, 1'b1);
                end
                else
                begin
                    if (q_count[own] > 1)
                        credit[own] = {1'b0, batch_limit_cfg};
                    pop_thread(own);
                    if (q_count[own] != 0)
                        node_waiting[own] = 1'b1;
                    lock_taken = 1'b0;
                    if (node_waiting == '0)
                        queue_outcome(ncla_pkg::K_RELEASED, tid, own, 1'b1);
                    else
                    begin
                        queue_outcome(ncla_pkg::K_RELEASED, tid, own, 1'b0);
                        // Round-robin pick of the next waiting node head
                        picked = 1'b0;
                        for (i = 0; i < NODES; i++)
                        begin
                            m = rr_next + i[ncla_pkg::NID_W-1:0];
                            if (!picked && node_waiting[m])
                            begin
                                picked          = 1'b1;
                                node_waiting[m] = 1'b0;
                                lock_taken      = 1'b1;
                                lock_node       = m;
                                rr_next         = m + ncla_pkg::NID_W'(1);
                                queue_outcome(ncla_pkg::K_GRANTED, fifo_mem[m][q_head[m]],
                                              m, 1'b1);
                            end
                        end
                    end
                end
            end
            default:
                queue_outcome(ncla_pkg::K_ERROR, tid, nid, 1'b1);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request; hold it until the transfer, then predict. Valid is
    // left high so that a back-to-back request needs no drop in between.
    task automatic send_request(input logic [ncla_pkg::OP_W-1:0] op,
                                input logic [ncla_pkg::TID_W-1:0] tid,
                                input logic [ncla_pkg::NID_W-1:0] nid);
        int gap;
        gap = 0;
        if (src_stall_on && !quiet_tail && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        thread_id <= tid;
        node_id   <= nid;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        arbitrate(op, tid, nid);
        requests_sent++;
    endtask

    // Drop valid and wait until every outcome has arrived and the block is quiet.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write batch_limit; call only while the block is idle.
    task automatic write_batch_limit(input logic [ncla_pkg::BATCH_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        batch_limit_cfg = value;
    endtask

    // Mostly well-formed traffic: locks from random threads, unlocks by the
    // current owner, some trylocks; the rest stray unlocks and illegal codes.
    task automatic random_traffic(input int count, input int lock_pct);
        int                         i;
        int                         roll;
        logic [ncla_pkg::OP_W-1:0]  op;
        logic [ncla_pkg::TID_W-1:0] tid;
        logic [ncla_pkg::NID_W-1:0] nid;
        for (i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            tid  = ncla_pkg::TID_W'($urandom_range(0, THREADS - 1));
            nid  = ncla_pkg::NID_W'($urandom_range(0, NODES - 1));
            if (roll < lock_pct)
                op = ncla_pkg::OP_LOCK;
            else if (roll < lock_pct + 10)
                op = ncla_pkg::OP_TRYLOCK;
            else if (roll < 94 && lock_taken)
            begin
                op  = ncla_pkg::OP_UNLOCK;
                tid = fifo_mem[lock_node][q_head[lock_node]];
                if ($urandom_range(0, 1) == 0)
                    nid = lock_node;
            end
            else if (roll < 97)
                op = ncla_pkg::OP_UNLOCK;
            else
                op = OP_ILLEGAL;
            send_request(op, tid, nid);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk through every request kind and the unlock and illegal-code errors by hand, at reset batch limit.
    task automatic test_directed();
        send_request(ncla_pkg::OP_UNLOCK, 6'd0, 2'd0);     // unlock of a free lock
        send_request(OP_ILLEGAL, 6'd63, 2'd3);             // illegal code, top ids
        send_request(OP_ILLEGAL, 6'd0, 2'd0);
        send_request(ncla_pkg::OP_TRYLOCK, 6'd5, 2'd0);    // free lock: granted
        send_request(ncla_pkg::OP_TRYLOCK, 6'd6, 2'd0);    // own node queue not empty
        send_request(ncla_pkg::OP_TRYLOCK, 6'd7, 2'd1);    // global lock held elsewhere
        send_request(ncla_pkg::OP_LOCK, 6'd8, 2'd0);       // behind the head
        send_request(ncla_pkg::OP_LOCK, 6'd9, 2'd1);       // new head waits globally
        send_request(ncla_pkg::OP_LOCK, 6'd10, 2'd2);
        send_request(ncla_pkg::OP_UNLOCK, 6'd8, 2'd0);     // not the owner
        send_request(ncla_pkg::OP_UNLOCK, 6'd5, 2'd0);     // no credit yet: release, regrant
        send_request(ncla_pkg::OP_UNLOCK, 6'd8, 2'd0);     // pass to the next waiting node
        send_request(ncla_pkg::OP_LOCK, 6'd11, 2'd1);
        send_request(ncla_pkg::OP_UNLOCK, 6'd9, 2'd1);     // loads credit on node 1
        send_request(ncla_pkg::OP_LOCK, 6'd12, 2'd2);
        send_request(ncla_pkg::OP_UNLOCK, 6'd10, 2'd2);
        send_request(ncla_pkg::OP_LOCK, 6'd13, 2'd1);
        send_request(ncla_pkg::OP_UNLOCK, 6'd11, 2'd1);    // same-node handoff on credit
        send_request(ncla_pkg::OP_UNLOCK, 6'd13, 2'd1);
        send_request(ncla_pkg::OP_UNLOCK, 6'd12, 2'd2);    // nobody waits: plain release
        send_request(ncla_pkg::OP_LOCK, 6'd0, 2'd3);
        send_request(ncla_pkg::OP_LOCK, 6'd63, 2'd3);
        send_request(ncla_pkg::OP_UNLOCK, 6'd0, 2'd0);     // node field is ignored on unlock
        send_request(ncla_pkg::OP_UNLOCK, 6'd63, 2'd2);
    endtask

    // Fill one node FIFO to the brim, overflow it, then drain it with a zero
    // batch limit, which takes effect only when the node's credit is reloaded.
    task automatic test_full_queue();
        int i;
        for (i = 0; i <= THREADS; i++)
            send_request(ncla_pkg::OP_LOCK,
                         ncla_pkg::TID_W'($urandom_range(0, THREADS - 1)), 2'd2);
        for (i = 0; i < THREADS; i++)
            send_request(ncla_pkg::OP_UNLOCK, fifo_mem[lock_node][q_head[lock_node]], 2'd2);
    endtask

    // Starve the result side while requests keep coming, so the input backs up.
    task automatic test_backpressure();
        pressure_kick <= 1'b1;
        @(posedge clk);
        pressure_kick <= 1'b0;
        random_traffic(60, 45);
    endtask

    // Random traffic across batch limits and stall mixes.
    task automatic test_batch_sweep();
        src_stall_on  <= 1'b1;
        sink_stall_on <= 1'b1;
        write_batch_limit(8'd1);
        random_traffic(300, 45);
        wait_idle();

        src_stall_on  <= 1'b1;
        sink_stall_on <= 1'b0;
        write_batch_limit(8'd255);
        random_traffic(300, 50);
        wait_idle();

        src_stall_on  <= 1'b0;
        sink_stall_on <= 1'b1;
        write_batch_limit(ncla_pkg::BATCH_W'($urandom_range(2, 254)));
        random_traffic(300, 35);
        wait_idle();

        src_stall_on  <= 1'b1;
        sink_stall_on <= 1'b1;
        write_batch_limit(8'd0);
        random_traffic(300, 45);
        wait_idle();
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_streaming();
        quiet_tail <= 1'b1;
        write_batch_limit(ncla_pkg::BATCH_W'($urandom_range(2, 8)));
        random_traffic(250, 45);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        opcode        <= ncla_pkg::OP_LOCK;
        thread_id     <= '0;
        node_id       <= '0;
        out_ready     <= 1'b0;
        src_stall_on  <= 1'b1;
        sink_stall_on <= 1'b1;
        quiet_tail    <= 1'b0;
        pressure_kick <= 1'b0;
        pressure_left <= 0;
        sink_gap      <= 0;
        for (n = 0; n < NODES; n++)
        begin
            q_head[n]        = '0;
            q_count[n]       = '0;
            grant_pending[n] = 1'b0;
            credit[n]        = '0;
        end
        lock_taken      = 1'b0;
        lock_node       = '0;
        node_waiting    = '0;
        rr_next         = '0;
        batch_limit_cfg = ncla_pkg::BATCH_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_idle();
        write_batch_limit(8'd0);
        test_full_queue();
        wait_idle();
        write_batch_limit(8'd255);
        test_backpressure();
        wait_idle();
        test_batch_sweep();
        test_streaming();
        wait_idle();
        repeat (16) @(posedge clk);

        if (outcome_q.size() != 0)
            failures++;
        $display("Ran %0d requests over batch limits 0 to 255, a full node FIFO and a long %s",
                 requests_sent, "output stall;");
        $display("seen %0d grants (%0d handoffs), %0d queued, %0d busy, %0d releases, %0d errors",
                 seen_granted, handoffs, seen_queued, seen_busy, seen_released, seen_error);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ncla_pkg.sv
hw/rtl/ncla_queue_mem.sv
hw/rtl/ncla_out_stage.sv
hw/rtl/numa_cohort_lock_arbiter_core.sv
bench/numa_cohort_lock_arbiter_core_test.sv
